[hdl/gcic_pkg.sv]
// Shared types and constants for the grid coordinate and index converter.
// Used by the pipelined divider and by the top level; depends on nothing.
`default_nettype none

package gcic_pkg;

  localparam int FIELD_BITS = 16;
  localparam int LIN_BITS   = 48;
  localparam int IDX_BITS   = 49;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = (LIN_BITS + DIV_STEP - 1) / DIV_STEP;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t REG_DIMENSIONS = 2'd0;
  localparam cfg_index_t REG_SIZE_X     = 2'd1;
  localparam cfg_index_t REG_SIZE_Y     = 2'd2;
  localparam cfg_index_t REG_SIZE_Z     = 2'd3;

  typedef enum logic {
    ACT_POS_TO_INDEX = 1'b0,
    ACT_INDEX_TO_POS = 1'b1
  } action_t;

endpackage

`default_nettype wire

[hdl/gcic_div.sv]
// Pipelined restoring divider, DIV_STEP quotient bits per stage, with sideband.
// Uses gcic_pkg for the number of bits resolved per stage.
`default_nettype none

module gcic_div #(
  parameter int NUM_BITS  = 48,
  parameter int DEN_BITS  = 16,
  parameter int SIDE_BITS = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [NUM_BITS-1:0]  num,
  input  wire logic [DEN_BITS-1:0]  den,
  input  wire logic [SIDE_BITS-1:0] side_in,
  output logic                      out_valid,
  output logic [NUM_BITS-1:0]       quo,
  output logic [DEN_BITS-1:0]       rem,
  output logic [SIDE_BITS-1:0]      side_out
);
  import gcic_pkg::*;

  localparam int STAGES = (NUM_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int PAD    = STAGES * DIV_STEP;

  logic                 stg_valid [STAGES+1];
  logic [DEN_BITS-1:0]  stg_rem   [STAGES+1];
  logic [PAD-1:0]       stg_num   [STAGES+1];
  logic [PAD-1:0]       stg_quo   [STAGES+1];
  logic [DEN_BITS-1:0]  stg_den   [STAGES+1];
  logic                 stg_zero  [STAGES+1];
  logic [SIDE_BITS-1:0] stg_side  [STAGES+1];

  assign stg_valid[0] = in_valid;
  assign stg_rem[0]   = '0;
  assign stg_num[0]   = PAD'(num);
  assign stg_quo[0]   = '0;
  assign stg_den[0]   = den;
  assign stg_zero[0]  = (den == '0);
  assign stg_side[0]  = side_in;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DEN_BITS:0] r_w;
    logic [PAD-1:0]    n_w;
    logic [PAD-1:0]    q_w;

    // With a zero divisor the quotient register collects the dividend itself.
    always_comb begin
      r_w = {1'b0, stg_rem[s]};
      n_w = stg_num[s];
      q_w = stg_quo[s];
      for (int k = 0; k < DIV_STEP; k++) begin
        r_w = {r_w[DEN_BITS-1:0], n_w[PAD-1]};
        n_w = {n_w[PAD-2:0], 1'b0};
        if (stg_zero[s]) begin
          q_w = {q_w[PAD-2:0], r_w[0]};
        end else if (r_w >= {1'b0, stg_den[s]}) begin
          r_w = r_w - {1'b0, stg_den[s]};
          q_w = {q_w[PAD-2:0], 1'b1};
        end else begin
          q_w = {q_w[PAD-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[s+1] <= 1'b0;
      end else begin
        stg_valid[s+1] <= stg_valid[s];
      end
      stg_rem[s+1]  <= r_w[DEN_BITS-1:0];
      stg_num[s+1]  <= n_w;
      stg_quo[s+1]  <= q_w;
      stg_den[s+1]  <= stg_den[s];
      stg_zero[s+1] <= stg_zero[s];
      stg_side[s+1] <= stg_side[s];
    end
  end

  assign out_valid = stg_valid[STAGES];
  assign quo       = stg_zero[STAGES] ? '0 : stg_quo[STAGES][NUM_BITS-1:0];
  assign rem       = stg_zero[STAGES] ? stg_quo[STAGES][DEN_BITS-1:0] : stg_rem[STAGES];
  assign side_out  = stg_side[STAGES];

endmodule

`default_nettype wire

[hdl/grid_coordinate_index_convert.sv]
// Top level of the row-major grid coordinate and index converter.
// Depends on gcic_pkg and on the pipelined divider gcic_div.
`default_nettype none

// Usage:
// An item is accepted at each rising edge where start is high; busy is always
// low, so a new item may be given in every cycle. Action zero maps a signed
// position to its linear index and checks it against the grid; action one
// maps a linear index back to a position and checks it against the grid size.
// Each item gives exactly one result, shown for one cycle with done high.
// The multiply and add stages are followed by two chained dividers that each
// resolve two quotient bits per stage. Throughput is one item per cycle.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and must be written only while no item is in flight.
// Reset empties the pipeline and sets three dimensions with all sizes one.
// Results cannot be held off by the receiver.
module grid_coordinate_index_convert #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 action,
  input  wire logic signed [gcic_pkg::FIELD_BITS-1:0] pos_x,
  input  wire logic signed [gcic_pkg::FIELD_BITS-1:0] pos_y,
  input  wire logic signed [gcic_pkg::FIELD_BITS-1:0] pos_z,
  input  wire logic [gcic_pkg::LIN_BITS-1:0]        lin_index,
  output logic                                      done,
  output logic                                      in_range,
  output logic signed [gcic_pkg::IDX_BITS-1:0]      out_index,
  output logic [gcic_pkg::FIELD_BITS-1:0]           out_x,
  output logic [gcic_pkg::FIELD_BITS-1:0]           out_y,
  output logic [gcic_pkg::FIELD_BITS-1:0]           out_z,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire gcic_pkg::cfg_index_t                 cfg_index,
  input  wire logic [gcic_pkg::FIELD_BITS-1:0]      cfg_data
);
  import gcic_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int EXT   = (CW > FIELD_BITS) ? CW : FIELD_BITS;
  localparam int MW    = (CW < FIELD_BITS) ? CW : FIELD_BITS;
  localparam int PW    = CW + 2 * FIELD_BITS + 1;
  localparam int SIDE1 = 2 + IDX_BITS + FIELD_BITS;
  localparam int SIDE2 = 2 + IDX_BITS + FIELD_BITS;
  localparam int LAT   = 4 + 2 * DIV_STAGES;

  logic [1:0]            dimensions;
  logic [FIELD_BITS-1:0] size_x;
  logic [FIELD_BITS-1:0] size_y;
  logic [FIELD_BITS-1:0] size_z;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimensions <= 2'd3;
      size_x     <= FIELD_BITS'(1);
      size_y     <= FIELD_BITS'(1);
      size_z     <= FIELD_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIMENSIONS: dimensions <= cfg_data[1:0];
        REG_SIZE_X:     size_x     <= cfg_data;
        REG_SIZE_Y:     size_y     <= cfg_data;
        REG_SIZE_Z:     size_z     <= cfg_data;
        default:        dimensions <= dimensions;
      endcase
    end
  end

  // Entry: coordinates, effective sizes and the position range check.
  logic [EXT-1:0]        x_ext, y_ext, z_ext;
  logic signed [CW-1:0]  px_c, py_c, pz_c;
  logic                  use_y, use_z;
  logic                  ok_x, ok_y, ok_z;

  assign x_ext = EXT'($unsigned(pos_x));
  assign y_ext = EXT'($unsigned(pos_y));
  assign z_ext = EXT'($unsigned(pos_z));
  assign px_c  = signed'(x_ext[CW-1:0]);
  assign py_c  = signed'(y_ext[CW-1:0]);
  assign pz_c  = signed'(z_ext[CW-1:0]);
  assign use_y = (dimensions == 2'd2) || (dimensions == 2'd3);
  assign use_z = (dimensions == 2'd3);
  assign ok_x  = !px_c[CW-1] && (EXT'($unsigned(px_c)) < EXT'(size_x));
  assign ok_y  = !py_c[CW-1] && (EXT'($unsigned(py_c)) < EXT'(size_y));
  assign ok_z  = !pz_c[CW-1] && (EXT'($unsigned(pz_c)) < EXT'(size_z));

  logic                  v1, act1, pok1;
  logic signed [CW-1:0]  px1, py1, pz1;
  logic [FIELD_BITS-1:0] sx1, sy1, sz1;
  logic [LIN_BITS-1:0]   li1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    act1 <= action;
    pok1 <= ok_x && (!use_y || ok_y) && (!use_z || ok_z);
    px1  <= px_c;
    py1  <= use_y ? py_c : '0;
    pz1  <= use_z ? pz_c : '0;
    sx1  <= size_x;
    sy1  <= use_y ? size_y : FIELD_BITS'(1);
    sz1  <= use_z ? size_z : FIELD_BITS'(1);
    li1  <= lin_index;
  end

  logic                         v2, act2, pok2;
  logic signed [CW-1:0]         px2, pz2;
  logic signed [CW+FIELD_BITS:0] pysz2;
  logic [2*FIELD_BITS-1:0]      plane2;
  logic [FIELD_BITS-1:0]        sx2, sy2, sz2;
  logic [LIN_BITS-1:0]          li2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    act2   <= act1;
    pok2   <= pok1;
    px2    <= px1;
    pz2    <= pz1;
    pysz2  <= py1 * $signed({1'b0, sz1});
    plane2 <= sy1 * sz1;
    sx2    <= sx1;
    sy2    <= sy1;
    sz2    <= sz1;
    li2    <= li1;
  end

  logic                   v3, act3, pok3;
  logic signed [PW-1:0]   pxp3;
  logic signed [PW-1:0]   rest3;
  logic [LIN_BITS-1:0]    total3;
  logic [FIELD_BITS-1:0]  sy3, sz3;
  logic [LIN_BITS-1:0]    li3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    act3   <= act2;
    pok3   <= pok2;
    pxp3   <= PW'(px2) * PW'($signed({1'b0, plane2}));
    rest3  <= PW'(pysz2 + pz2);
    total3 <= sx2 * plane2;
    sy3    <= sy2;
    sz3    <= sz2;
    li3    <= li2;
  end

  logic                        v4, act4, ok4;
  logic signed [IDX_BITS-1:0]  idx4;
  logic [FIELD_BITS-1:0]       sy4, sz4;
  logic [LIN_BITS-1:0]         li4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    act4 <= act3;
    ok4  <= (act3 == ACT_INDEX_TO_POS) ? (li3 < total3) : pok3;
    idx4 <= IDX_BITS'(pxp3 + rest3);
    sy4  <= sy3;
    sz4  <= sz3;
    li4  <= li3;
  end

  // First divider splits off the fastest axis, the second the middle axis.
  logic                  d1_valid;
  logic [LIN_BITS-1:0]   d1_quo;
  logic [FIELD_BITS-1:0] d1_rem;
  logic [SIDE1-1:0]      d1_side;
  logic [FIELD_BITS-1:0] d1_sy;

  gcic_div #(
    .NUM_BITS  (LIN_BITS),
    .DEN_BITS  (FIELD_BITS),
    .SIDE_BITS (SIDE1)
  ) u_div_z (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .num       (li4),
    .den       (sz4),
    .side_in   ({act4, ok4, idx4, sy4}),
    .out_valid (d1_valid),
    .quo       (d1_quo),
    .rem       (d1_rem),
    .side_out  (d1_side)
  );

  assign d1_sy = d1_side[FIELD_BITS-1:0];

  logic                  d2_valid;
  logic [LIN_BITS-1:0]   d2_quo;
  logic [FIELD_BITS-1:0] d2_rem;
  logic [SIDE2-1:0]      d2_side;

  gcic_div #(
    .NUM_BITS  (LIN_BITS),
    .DEN_BITS  (FIELD_BITS),
    .SIDE_BITS (SIDE2)
  ) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d1_valid),
    .num       (d1_quo),
    .den       (d1_sy),
    .side_in   ({d1_side[SIDE1-1:FIELD_BITS], d1_rem}),
    .out_valid (d2_valid),
    .quo       (d2_quo),
    .rem       (d2_rem),
    .side_out  (d2_side)
  );

  logic                       r_act;
  logic signed [IDX_BITS-1:0] r_idx;
  logic [FIELD_BITS-1:0]      r_oz;

  assign r_act = d2_side[SIDE2-1];
  assign r_idx = d2_side[IDX_BITS+FIELD_BITS-1:FIELD_BITS];
  assign r_oz  = d2_side[FIELD_BITS-1:0];

  assign done      = d2_valid;
  assign in_range  = d2_side[SIDE2-2];
  assign out_index = (r_act == ACT_INDEX_TO_POS) ? '0 : r_idx;
  assign out_x     = (r_act == ACT_INDEX_TO_POS) ? FIELD_BITS'(d2_quo[MW-1:0]) : '0;
  assign out_y     = (r_act == ACT_INDEX_TO_POS) ? FIELD_BITS'(d2_rem[MW-1:0]) : '0;
  assign out_z     = (r_act == ACT_INDEX_TO_POS) ? FIELD_BITS'(r_oz[MW-1:0]) : '0;

  a_done_follows_start : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("Result appeared without a matching accepted item.");

  a_one_kind_of_result : assert property (@(posedge clk) disable iff (rst)
    done && (out_index != '0) |-> (out_x == '0) && (out_y == '0) && (out_z == '0))
    else $error("Result mixes an index with recovered coordinates.");

  a_z_needs_three_axes : assert property (@(posedge clk) disable iff (rst)
    done && (out_z != '0) |-> (dimensions == 2'd3))
    else $error("Third coordinate is nonzero with fewer than three axes.");

  a_y_needs_two_axes : assert property (@(posedge clk) disable iff (rst)
    done && (out_y != '0) |-> (dimensions == 2'd2) || (dimensions == 2'd3))
    else $error("Second coordinate is nonzero with a single axis.");

endmodule

`default_nettype wire
